### hdl/wptd_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint controller package
// Shared types, command codes, register indexes and the arctangent table.
// ----------------------------------------------------------------------------
package wptd_pkg;

   localparam int unsigned QueueDepth = 2;

   typedef enum logic [1:0] {
      CMD_POSE = 2'd0,
      CMD_GOAL = 2'd1,
      CMD_TICK = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_ANGULAR_GAIN = 3'd0,
      REG_LINEAR_GAIN  = 3'd1,
      REG_DIST_FAR     = 3'd2,
      REG_DIST_NEAR    = 3'd3,
      REG_ANGLE_FAR    = 3'd4,
      REG_ANGLE_NEAR   = 3'd5,
      REG_FINAL_TOL    = 3'd6,
      REG_UNUSED       = 3'd7
   } reg_index_type;

   // A tick as passed from the front end to the back end.  Poses are
   // captured at acceptance so later updates cannot disturb it.  The goal_new
   // bit says that a goal request arrived since the previous tick, which
   // re-arms the waypoint before this tick is carried out.
   typedef struct packed {
      logic               seen;
      logic               goal_new;
      logic signed [20:0] dx;
      logic signed [20:0] dy;
      logic signed [15:0] robot_heading;
      logic signed [16:0] final_err;
   } tick_type;

   typedef struct packed {
      logic [11:0] angular_gain;
      logic [11:0] linear_gain;
      logic [15:0] distance_far;
      logic [15:0] distance_near;
      logic [14:0] angle_far;
      logic [14:0] angle_near;
      logic [14:0] final_tol;
   } cfg_type;

   localparam logic signed [21:0] PiQ12    = 22'sd12868;
   localparam logic signed [21:0] TwoPiQ12 = 22'sd25736;
   localparam logic signed [21:0] PiQ16    = 22'sd205887;

   function automatic logic signed [21:0] atan_entry(input logic [3:0] i);
      logic signed [21:0] v;
      case (i)
         4'd0:  v = 22'sd51472;
         4'd1:  v = 22'sd30385;
         4'd2:  v = 22'sd16055;
         4'd3:  v = 22'sd8150;
         4'd4:  v = 22'sd4091;
         4'd5:  v = 22'sd2047;
         4'd6:  v = 22'sd1024;
         4'd7:  v = 22'sd512;
         4'd8:  v = 22'sd256;
         4'd9:  v = 22'sd128;
         4'd10: v = 22'sd64;
         4'd11: v = 22'sd32;
         4'd12: v = 22'sd16;
         4'd13: v = 22'sd8;
         4'd14: v = 22'sd4;
         default: v = 22'sd2;
      endcase
      return v;
   endfunction

endpackage

### hdl/waypoint_turn_then_drive_controller.sv
// ----------------------------------------------------------------------------
// Waypoint turn-then-drive controller
// Proportional go-to-goal controller with hysteresis on location and heading.
// ----------------------------------------------------------------------------
// Pose and goal requests are absorbed by the front end; like ticks, they are
// stalled while the queue is full. A tick request is queued (two deep) and
// handled by the back end in order: the bit-serial square root of the
// distance, the vectoring CORDIC, then the decision and output. The result is held
// until the consumer takes it. A result is produced only for ticks. A goal
// request re-arms the waypoint for the next tick that follows it, so the
// active flag always matches the order in which requests were accepted.
module waypoint_turn_then_drive_controller #(
   parameter int unsigned QDEPTH = wptd_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [19:0] req_pos_x,
   input  logic signed [19:0] req_pos_y,
   input  logic signed [15:0] req_heading,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [14:0]        rsp_linear_velocity,
   output logic signed [15:0] rsp_angular_velocity,
   output logic               rsp_goal_active,
   output logic               rsp_location_reached,
   output logic               rsp_heading_aligned,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import wptd_pkg::*;

   cfg_type  cfg_ff;
   tick_type q_tick;
   logic     q_valid, q_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angular_gain  <= 12'd1434;
         cfg_ff.linear_gain   <= 12'd2703;
         cfg_ff.distance_far  <= 16'd205;
         cfg_ff.distance_near <= 16'd123;
         cfg_ff.angle_far     <= 15'd614;
         cfg_ff.angle_near    <= 15'd410;
         cfg_ff.final_tol     <= 15'd205;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_ANGULAR_GAIN: cfg_ff.angular_gain  <= csr_data[11:0];
            REG_LINEAR_GAIN:  cfg_ff.linear_gain   <= csr_data[11:0];
            REG_DIST_FAR:     cfg_ff.distance_far  <= csr_data;
            REG_DIST_NEAR:    cfg_ff.distance_near <= csr_data;
            REG_ANGLE_FAR:    cfg_ff.angle_far     <= csr_data[14:0];
            REG_ANGLE_NEAR:   cfg_ff.angle_near    <= csr_data[14:0];
            REG_FINAL_TOL:    cfg_ff.final_tol     <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   wptd_front #(.QDEPTH(QDEPTH)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd, .req_pos_x,
      .req_pos_y, .req_heading, .q_valid, .q_take, .q_tick
   );

   wptd_back u_back (
      .clock, .reset, .cfg(cfg_ff), .q_valid, .q_take, .q_tick,
      .rsp_valid, .rsp_stall,
      .rsp_linear_velocity, .rsp_angular_velocity, .rsp_goal_active,
      .rsp_location_reached, .rsp_heading_aligned
   );

`ifndef ASSERT_OFF
   // A turn and a drive are never commanded together.
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_linear_velocity == '0 || rsp_angular_velocity == '0))
      else $error("turn and drive together");
   // A forward command only ever comes with an active goal.
   a_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_goal_active && rsp_linear_velocity != '0) |-> 1'b0)
      else $error("drive without active goal");
`endif
endmodule

### hdl/wptd_front.sv
// ----------------------------------------------------------------------------
// Waypoint controller front end
// Takes requests, keeps the robot and goal poses and queues ticks.
// ----------------------------------------------------------------------------
module wptd_front #(
   parameter int unsigned QDEPTH = wptd_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_cmd,
   input  logic signed [19:0]     req_pos_x,
   input  logic signed [19:0]     req_pos_y,
   input  logic signed [15:0]     req_heading,
   output logic                   q_valid,
   input  logic                   q_take,
   output wptd_pkg::tick_type     q_tick
);
   import wptd_pkg::*;

   localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

   logic signed [19:0] rx_ff, ry_ff, gx_ff, gy_ff;
   logic signed [15:0] rh_ff, gh_ff;
   logic               seen_ff, goal_new_ff;
   tick_type           mem_ff [QDEPTH];
   logic [PW-1:0]      wp_ff, rp_ff;
   logic [PW:0]        cnt_ff, cnt_in;
   logic               acc, push;
   cmd_type            cmd;
   tick_type           t;

   assign cmd       = cmd_type'(req_cmd);
   assign req_stall = (cnt_ff == (PW+1)'(QDEPTH));
   assign acc       = req_valid && !req_stall;
   assign push      = acc && cmd == CMD_TICK;
   assign q_valid   = cnt_ff != '0;
   assign q_tick    = mem_ff[rp_ff];

   always_comb begin
      t.seen          = seen_ff;
      t.goal_new      = goal_new_ff;
      t.dx            = 21'(gx_ff) - 21'(rx_ff);
      t.dy            = 21'(gy_ff) - 21'(ry_ff);
      t.robot_heading = rh_ff;
      t.final_err     = 17'(gh_ff) - 17'(rh_ff);
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(q_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff <= '0; ry_ff <= '0; rh_ff <= '0;
         gx_ff <= '0; gy_ff <= '0; gh_ff <= '0;
         seen_ff <= 1'b0; goal_new_ff <= 1'b0;
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (acc && cmd == CMD_POSE) begin
            rx_ff <= req_pos_x; ry_ff <= req_pos_y; rh_ff <= req_heading;
         end
         if (acc && cmd == CMD_GOAL) begin
            gx_ff <= req_pos_x; gy_ff <= req_pos_y; gh_ff <= req_heading;
            seen_ff <= 1'b1; goal_new_ff <= 1'b1;
         end
         if (push) begin
            mem_ff[wp_ff] <= t;
            goal_new_ff <= 1'b0;
            wp_ff <= (wp_ff == PW'(QDEPTH - 1)) ? '0 : wp_ff + PW'(1);
         end
         if (q_take) rp_ff <= (rp_ff == PW'(QDEPTH - 1)) ? '0 : rp_ff + PW'(1);
      end
   end
endmodule

### hdl/wptd_back.sv
// ----------------------------------------------------------------------------
// Waypoint controller back end
// Square root, vectoring CORDIC and the command decision, one tick at a time.
// ----------------------------------------------------------------------------
module wptd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  wptd_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   output logic                 q_take,
   input  wptd_pkg::tick_type   q_tick,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [14:0]          rsp_linear_velocity,
   output logic signed [15:0]   rsp_angular_velocity,
   output logic                 rsp_goal_active,
   output logic                 rsp_location_reached,
   output logic                 rsp_heading_aligned
);
   import wptd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SQRT  = 6'b000010,
      ST_LOC   = 6'b000100,
      ST_CORD  = 6'b001000,
      ST_DEC   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   tick_type           tk_ff;
   logic [21:0]        root_ff;
   logic [4:0]         step_ff;
   logic signed [42:0] cx_ff, cy_ff;
   logic signed [21:0] z_ff;
   logic signed [17:0] err_ff;
   logic               loc_ff, ang_ff;
   logic [14:0]        lin_ff, lin_in;
   logic signed [15:0] angv_ff, angv_in;
   logic               act_ff;

   // Squared distance, formed as the tick leaves the queue.
   logic [20:0] adx, ady;
   logic [41:0] sqx, sqy;
   logic [43:0] dd, dd_ff;
   logic [4:0]  bi;
   always_comb begin
      adx = q_tick.dx[20] ? 21'(-q_tick.dx) : 21'(q_tick.dx);
      ady = q_tick.dy[20] ? 21'(-q_tick.dy) : 21'(q_tick.dy);
      sqx = adx * adx;
      sqy = ady * ady;
      dd  = 44'(sqx) + 44'(sqy);
      bi  = 5'd21 - step_ff;
   end

   // Square root: one result bit a cycle.
   logic [44:0] sq_r_ff;
   logic [22:0] sq_q_ff;
   logic [44:0] sq_r_in;
   logic [24:0] sq_t;
   logic [44:0] sq_sub;
   always_comb begin
      sq_r_in = {sq_r_ff[42:0], dd_ff[6'(2*bi+1)], dd_ff[6'(2*bi)]};
      sq_t    = {sq_q_ff, 2'b01};
      sq_sub  = sq_r_in - 45'(sq_t);
   end

   // CORDIC step.
   logic [3:0]         ci;
   logic signed [42:0] sx, sy;
   logic signed [42:0] nx, ny;
   logic signed [21:0] nz, bearing, e1, e2;
   always_comb begin
      ci = step_ff[3:0];
      sx = cx_ff >>> ci;
      sy = cy_ff >>> ci;
      if (cy_ff > 0) begin
         nx = cx_ff + sy; ny = cy_ff - sx; nz = z_ff + atan_entry(ci);
      end else begin
         nx = cx_ff - sy; ny = cy_ff + sx; nz = z_ff - atan_entry(ci);
      end
      bearing = (z_ff + 22'sd8) >>> 4;
      e1 = bearing - 22'(tk_ff.robot_heading);
      if (e1 > PiQ12) e2 = e1 - TwoPiQ12;
      else if (e1 < -PiQ12) e2 = e1 + TwoPiQ12;
      else e2 = e1;
   end

   // Decision.
   logic [17:0]        aerr, afin;
   logic               amet;
   logic signed [31:0] pa;
   logic [34:0]        pl;
   logic signed [19:0] ra;
   logic [22:0]        rl;
   logic               dfar, dnear, lmet;
   logic               turn, drive, lm2, gclr;
   always_comb begin
      dfar  = root_ff >= 22'(cfg.distance_far);
      dnear = root_ff <  22'(cfg.distance_near);
      lmet  = dfar ? 1'b0 : (dnear ? 1'b1 : loc_ff);
      aerr  = err_ff[17] ? 18'(-err_ff) : 18'(err_ff);
      afin  = tk_ff.final_err[16] ? 18'(-18'(tk_ff.final_err)) : 18'(tk_ff.final_err);
      amet  = (aerr > 18'(cfg.angle_far)) ? 1'b0 :
              ((aerr < 18'(cfg.angle_near)) ? 1'b1 : ang_ff);
      pa = 32'(err_ff) * $signed({20'd0, cfg.angular_gain}) + 32'sd2048;
      pl = 35'(root_ff) * 35'(cfg.linear_gain) + 35'd2048;
      ra = 20'(pa >>> 12);
      rl = pl[34:12];
      turn  = act_ff && !amet;
      drive = act_ff && dfar && !loc_ff;
      lm2   = (turn || drive) ? loc_ff : 1'b1;
      gclr  = lm2 && (afin < 18'(cfg.final_tol));
      lin_in  = '0;
      angv_in = '0;
      if (turn) begin
         angv_in = (ra > 20'sd32767) ? 16'sh7FFF :
                   (ra < -20'sd32768) ? 16'sh8000 : 16'(ra);
      end else if (drive) begin
         lin_in = (rl > 23'd32767) ? 15'h7FFF : 15'(rl);
      end
   end

   assign q_take     = state_ff == ST_IDLE && q_valid;
   assign rsp_valid  = state_ff == ST_OUT;
   assign rsp_linear_velocity  = lin_ff;
   assign rsp_angular_velocity = angv_ff;
   assign rsp_goal_active      = act_ff;
   assign rsp_location_reached = loc_ff;
   assign rsp_heading_aligned  = ang_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (q_valid) state_in = ST_SQRT;
         ST_SQRT: if (step_ff == 5'd21) state_in = ST_LOC;
         ST_LOC:  state_in = ST_CORD;
         ST_CORD: if (step_ff == 5'd16) state_in = ST_DEC;
         ST_DEC:  state_in = ST_OUT;
         ST_OUT:  if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         loc_ff <= 1'b1; ang_ff <= 1'b1; act_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               tk_ff <= q_tick; dd_ff <= dd; step_ff <= '0;
               sq_r_ff <= '0; sq_q_ff <= '0;
               if (q_valid && q_tick.goal_new) act_ff <= 1'b1;
            end
            ST_SQRT: begin
               if (!sq_sub[44]) begin
                  sq_r_ff <= sq_sub; sq_q_ff <= {sq_q_ff[21:0], 1'b1};
               end else begin
                  sq_r_ff <= sq_r_in; sq_q_ff <= {sq_q_ff[21:0], 1'b0};
               end
               step_ff <= step_ff + 5'd1;
            end
            ST_LOC: begin
               root_ff <= sq_q_ff[21:0];
               step_ff <= '0;
               if (tk_ff.dx[20]) begin
                  cx_ff <= -(43'(tk_ff.dx) <<< 20);
                  cy_ff <= -(43'(tk_ff.dy) <<< 20);
                  z_ff  <= tk_ff.dy[20] ? -PiQ16 : PiQ16;
               end else begin
                  cx_ff <= 43'(tk_ff.dx) <<< 20;
                  cy_ff <= 43'(tk_ff.dy) <<< 20;
                  z_ff  <= '0;
               end
            end
            ST_CORD: begin
               if (step_ff == 5'd16) begin
                  if (tk_ff.seen) begin
                     loc_ff <= lmet;
                     if (lmet) err_ff <= 18'(tk_ff.final_err);
                     else if (tk_ff.dx == '0 && tk_ff.dy == '0)
                        err_ff <= -18'(tk_ff.robot_heading);
                     else err_ff <= 18'(e2);
                  end
               end else begin
                  cx_ff <= nx; cy_ff <= ny; z_ff <= nz;
                  step_ff <= step_ff + 5'd1;
               end
            end
            ST_DEC: begin
               lin_ff  <= lin_in;
               angv_ff <= angv_in;
               if (tk_ff.seen) begin
                  ang_ff <= amet;
                  loc_ff <= lm2;
                  if (gclr) act_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
